/* hw/rtl/bcc_pkg.sv */
// shared types and constants of the button click classifier
package bcc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PDEB = 2'd1,
        PH_HELD = 2'd2,
        PH_RDEB = 2'd3
    } t_phase;

    typedef logic [2:0] t_event;
    typedef logic [2:0] t_clicks;
    typedef logic [15:0] t_cfg_val;
    typedef logic [1:0] t_cfg_idx;

    localparam t_event EV_NONE = 3'd0;
    localparam t_event EV_LONG = 3'd4;

    localparam t_clicks CLICKS_MAX    = 3'd4;
    localparam t_clicks CLICKS_REPORT = 3'd3;

    localparam t_cfg_idx REG_DEBOUNCE = 2'd0;
    localparam t_cfg_idx REG_LONG     = 2'd1;
    localparam t_cfg_idx REG_GAP      = 2'd2;

    localparam t_cfg_val DEBOUNCE_RST = 16'd20;
    localparam t_cfg_val LONG_RST     = 16'd1000;
    localparam t_cfg_val GAP_RST      = 16'd300;

endpackage

/* hw/rtl/bcc_intf.sv */
// handshake channel interfaces: sample input, event output, register write
interface bcc_in_if;
    logic        valid;
    logic        ready;
    logic        key_level;
    logic [31:0] now_ms;
    modport source (output valid, output key_level, output now_ms, input ready);
    modport sink   (input valid, input key_level, input now_ms, output ready);
endinterface

interface bcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_event;
    logic       is_pressed;
    modport source (output valid, output key_event, output is_pressed, input ready);
    modport sink   (input valid, input key_event, input is_pressed, output ready);
endinterface

interface bcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/button_click_classifier_core.sv */
// top level: debounced multi-click and long-press classifier
//
// Channels: i_in carries one scan sample per word (key_level, now_ms);
// o_out carries one word per sample (key_event, is_pressed); i_cfg writes
// register index 0 debounce_ms, 1 long_press_ms, 2 click_gap_ms (index 3
// is ignored). i_cfg.ready is always high.
// Timing: an accepted sample is held in the input register while the state
// machine and timer compares evaluate it, and the result word is loaded into
// the output register, which drives o_out.valid.
// Throughput: one sample per cycle while o_out is taken, set by the state
// update (one TIME_BITS subtract and three compares against 16-bit thresholds).
// Stall: while o_out holds an untaken word the pending sample waits in the
// input register and i_in.ready drops; nothing is lost or repeated.
// Reset: i_rst_n low clears both pipeline valids, the phase to idle, the
// timestamp mark, pressed and long-press flags and the click count, and
// restores the registers to 20, 1000 and 300 ms.
// Only the low TIME_BITS bits of now_ms are used; elapsed time wraps.
module button_click_classifier_core
    import bcc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bcc_in_if.sink       i_in,
    bcc_out_if.source    o_out,
    bcc_cfg_if.sink      i_cfg
);

    // configuration
    t_cfg_val r_debounce, r_long, r_gap;

    // input register
    logic                 r_in_valid;
    logic                 r_level;
    logic [TIME_BITS-1:0] r_now;

    // classifier state
    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_mark, n_mark;
    logic                 r_held, n_held;
    logic                 r_long_done, n_long_done;
    t_clicks              r_clicks, n_clicks;

    // output register
    logic   r_out_valid;
    t_event r_event, n_event;
    logic   r_pressed;

    logic                 out_free, fire, mark_upd;
    logic [TIME_BITS-1:0] elapsed, gap_elapsed;
    logic                 deb_done, long_due, gap_due;
    t_clicks              clicks_mid;

    assign out_free    = !r_out_valid || o_out.ready;
    assign fire        = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || out_free;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.key_event  = r_event;
    assign o_out.is_pressed = r_pressed;

    assign elapsed  = r_now - r_mark;
    assign deb_done = elapsed >= TIME_BITS'(r_debounce);
    assign long_due = elapsed >= TIME_BITS'(r_long);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (r_level) n_phase = PH_PDEB;
            end
            PH_PDEB: begin
                if (deb_done) n_phase = r_level ? PH_HELD : PH_IDLE;
            end
            PH_HELD: begin
                if (!r_level) n_phase = PH_RDEB;
            end
            PH_RDEB: begin
                if (deb_done) n_phase = r_level ? PH_HELD : PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // timestamp mark, flags, click count and event
    always_comb begin
        n_mark      = r_mark;
        n_held      = r_held;
        n_long_done = r_long_done;
        clicks_mid  = r_clicks;
        mark_upd    = 1'b0;
        n_event     = EV_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                if (r_level) mark_upd = 1'b1;
            end
            PH_PDEB: begin
                if (deb_done && r_level) begin
                    mark_upd    = 1'b1;
                    n_held      = 1'b1;
                    n_long_done = 1'b0;
                end
            end
            PH_HELD: begin
                if (!r_level) begin
                    mark_upd = 1'b1;
                end else if (long_due && !r_long_done) begin
                    n_long_done = 1'b1;
                    n_event     = EV_LONG;
                    clicks_mid  = '0;
                end
            end
            PH_RDEB: begin
                if (deb_done && !r_level) begin
                    n_held = 1'b0;
                    // a release after a long press is not a click
                    if (!r_long_done) begin
                        if (r_clicks < CLICKS_MAX) clicks_mid = r_clicks + 3'd1;
                        mark_upd = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (mark_upd) n_mark = r_now;

        // gap measured from the updated mark
        gap_elapsed = mark_upd ? '0 : elapsed;
        gap_due     = !n_held && (clicks_mid != '0) && (gap_elapsed > TIME_BITS'(r_gap));
        n_clicks    = clicks_mid;
        if (gap_due) begin
            if (clicks_mid <= CLICKS_REPORT) n_event = t_event'(clicks_mid);
            n_clicks = '0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_long     <= LONG_RST;
            r_gap      <= GAP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DEBOUNCE: r_debounce <= i_cfg.data;
                REG_LONG:     r_long     <= i_cfg.data;
                REG_GAP:      r_gap      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_level <= i_in.key_level;
            r_now   <= i_in.now_ms[TIME_BITS-1:0];
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_mark      <= '0;
            r_held      <= 1'b0;
            r_long_done <= 1'b0;
            r_clicks    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase     <= n_phase;
                r_mark      <= n_mark;
                r_held      <= n_held;
                r_long_done <= n_long_done;
                r_clicks    <= n_clicks;
            end
            r_out_valid <= fire || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_event   <= n_event;
            r_pressed <= n_held;
        end
    end

endmodule

/* verif/button_click_classifier_core_tb.sv */
// self-checking testbench of the button click classifier core
`timescale 1ns / 100ps

module button_click_classifier_core_tb;
    import bcc_pkg::*;

    localparam int TB_TIME_BITS = 32;
    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 185;
    localparam int N_SETTINGS   = 7;

    localparam t_cfg_idx REG_SPARE = 2'd3;

    typedef struct packed {
        t_event ev;
        logic   pressed;
    } click_word_t;

    typedef struct packed {
        logic        lvl;
        logic [31:0] stamp;
        logic        fixed;
        t_event      ev;
        logic        pressed;
    } plan_row_t;

    // long press across the timestamp wrap, then four quick clicks that are dropped
    localparam plan_row_t PLAN [23] = '{
        '{1'b0, 32'h0000_0000, 1'b1, EV_NONE, 1'b0},
        '{1'b1, 32'hFFFF_FFF0, 1'b1, EV_NONE, 1'b0},
        '{1'b1, 32'h0000_0004, 1'b1, EV_NONE, 1'b1},
        '{1'b1, 32'h0000_03EC, 1'b1, EV_LONG, 1'b1},
        '{1'b0, 32'h0000_0400, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0000_0414, 1'b0, EV_NONE, 1'b0},
        '{1'b1, 32'h0001_0000, 1'b0, EV_NONE, 1'b0},
        '{1'b1, 32'h0001_0014, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_0020, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_0034, 1'b0, EV_NONE, 1'b0},
        '{1'b1, 32'h0001_0040, 1'b0, EV_NONE, 1'b0},
        '{1'b1, 32'h0001_0054, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_0060, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_0074, 1'b0, EV_NONE, 1'b0},
        '{1'b1, 32'h0001_0080, 1'b0, EV_NONE, 1'b0},
        '{1'b1, 32'h0001_0094, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_00A0, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_00B4, 1'b0, EV_NONE, 1'b0},
        '{1'b1, 32'h0001_00C0, 1'b0, EV_NONE, 1'b0},
        '{1'b1, 32'h0001_00D4, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_00E0, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_00F4, 1'b0, EV_NONE, 1'b0},
        '{1'b0, 32'h0001_0221, 1'b1, EV_NONE, 1'b0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic rx_ready = 1'b0;

    bcc_in_if  smp_if ();
    bcc_out_if ev_if ();
    bcc_cfg_if reg_if ();

    assign ev_if.ready = rx_ready;

    button_click_classifier_core #(
        .TIME_BITS(TB_TIME_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (smp_if),
        .o_out  (ev_if),
        .i_cfg  (reg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // own copy of the classifier state and thresholds
    t_phase                  key_phase;
    logic [TB_TIME_BITS-1:0] mark_ms;
    logic                    held;
    logic                    long_seen;
    t_clicks                 click_cnt;
    t_cfg_val                deb_ms;
    t_cfg_val                long_ms;
    t_cfg_val                gap_ms;

    click_word_t pending_events [$];
    click_word_t got_word;
    int          n_errors   = 0;
    int          n_samples  = 0;
    int          n_cycles   = 0;
    int          stall_left = 0;
    int          stall_len;
    bit          no_gaps    = 1'b0;
    logic [31:0] clock_ms;

    function automatic click_word_t classify_sample(input logic lvl, input logic [31:0] raw);
        logic [TB_TIME_BITS-1:0] stamp;
        click_word_t             word;
        stamp = raw[TB_TIME_BITS-1:0];
        word.ev = EV_NONE;
        case (key_phase)
            PH_IDLE: begin
                if (lvl) begin
                    key_phase = PH_PDEB;
                    mark_ms = stamp;
                end
            end
            PH_PDEB: begin
                if (stamp - mark_ms >= TB_TIME_BITS'(deb_ms)) begin
                    if (lvl) begin
                        key_phase = PH_HELD;
                        mark_ms = stamp;
                        held = 1'b1;
                        long_seen = 1'b0;
                    end else begin
                        key_phase = PH_IDLE;
                    end
                end
            end
            PH_HELD: begin
                if (!lvl) begin
                    key_phase = PH_RDEB;
                    mark_ms = stamp;
                end else if (stamp - mark_ms >= TB_TIME_BITS'(long_ms) && !long_seen) begin
                    long_seen = 1'b1;
                    word.ev = EV_LONG;
                    click_cnt = '0;
                end
            end
            default: begin
                if (stamp - mark_ms >= TB_TIME_BITS'(deb_ms)) begin
                    if (!lvl) begin
                        held = 1'b0;
                        key_phase = PH_IDLE;
                        // a release that ends a long press is not a click
                        if (!long_seen) begin
                            if (click_cnt < CLICKS_MAX) click_cnt = click_cnt + 3'd1;
                            mark_ms = stamp;
                        end
                    end else begin
                        key_phase = PH_HELD;
                    end
                end
            end
        endcase
        if (!held && click_cnt != '0 && stamp - mark_ms > TB_TIME_BITS'(gap_ms)) begin
            if (click_cnt <= CLICKS_REPORT) word.ev = t_event'(click_cnt);
            click_cnt = '0;
        end
        word.pressed = held;
        return word;
    endfunction

    function automatic int gap_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (no_gaps || r < 60) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // time offset that lands on, next to, below, or well past a threshold
    function automatic logic [31:0] around(input logic [31:0] thr);
        case ($urandom_range(0, 5))
            0: return thr;
            1: return thr + 32'd1;
            2: return (thr > 0) ? thr - 32'd1 : 32'd0;
            3: return $urandom_range(0, thr);
            4: return thr + $urandom_range(2, 40);
            default: return $urandom_range(thr, 2 * thr + 3);
        endcase
    endfunction

    task automatic drive_sample(input logic lvl, input logic [31:0] stamp,
                                input logic fixed = 1'b0, input click_word_t fixed_word = '0);
        int          idle;
        click_word_t word;
        idle = gap_len();
        if (idle > 0) begin
            smp_if.valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        smp_if.valid     <= 1'b1;
        smp_if.key_level <= lvl;
        smp_if.now_ms    <= stamp;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        word = classify_sample(lvl, stamp);
        pending_events.push_back(fixed ? fixed_word : word);
        n_samples++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        smp_if.valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_val val);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        @(posedge i_clk);
        while (!reg_if.ready) @(posedge i_clk);
        case (idx)
            REG_DEBOUNCE: deb_ms = val;
            REG_LONG:     long_ms = val;
            REG_GAP:      gap_ms = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic program_thresholds(input t_cfg_val deb, input t_cfg_val lng,
                                      input t_cfg_val gap);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG, lng);
        write_reg(REG_GAP, gap);
        write_reg(REG_SPARE, t_cfg_val'($urandom()));
        reg_if.valid <= 1'b0;
    endtask

    // one burst of clicks with bounce, or a stretch of noise
    task automatic play_burst();
        int          n_clicks;
        logic [31:0] t0;
        logic        hold_long;
        no_gaps = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(3, 12)) begin
                clock_ms += $urandom_range(0, 2 * 32'(deb_ms) + 32'(gap_ms) + 8);
                drive_sample(1'($urandom_range(0, 1)), clock_ms);
            end
        end else begin
            n_clicks = int'($urandom_range(1, 5));
            for (int k = 0; k < n_clicks; k++) begin
                hold_long = ($urandom_range(0, 5) == 0);
                t0 = clock_ms;
                drive_sample(1'b1, t0);
                if ($urandom_range(0, 2) == 0)
                    drive_sample(1'($urandom_range(0, 1)),
                                 t0 + $urandom_range(0, 32'(deb_ms) / 2));
                clock_ms = t0 + around(32'(deb_ms));
                drive_sample(1'b1, clock_ms);
                t0 = clock_ms;
                if (hold_long) begin
                    clock_ms = t0 + around(32'(long_ms));
                    drive_sample(1'b1, clock_ms);
                    clock_ms += $urandom_range(0, 50);
                end else begin
                    clock_ms = t0 + $urandom_range(0, (long_ms > 0) ? 32'(long_ms) - 1 : 0);
                end
                t0 = clock_ms;
                drive_sample(1'b0, t0);
                if ($urandom_range(0, 2) == 0)
                    drive_sample(1'($urandom_range(0, 1)),
                                 t0 + $urandom_range(0, 32'(deb_ms) / 2));
                clock_ms = t0 + around(32'(deb_ms));
                drive_sample(1'b0, clock_ms);
                if (k < n_clicks - 1)
                    clock_ms += ($urandom_range(0, 3) == 0) ? around(32'(gap_ms))
                                                            : $urandom_range(0, 32'(gap_ms));
            end
            drive_sample(1'b0, clock_ms + around(32'(gap_ms)));
            clock_ms += 32'(gap_ms) + $urandom_range(1, 200);
            drive_sample(1'b0, clock_ms);
        end
    endtask

    // result side: random stalls on ready
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rx_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            stall_len = gap_len();
            rx_ready <= (stall_len == 0);
            stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ev_if.valid && ev_if.ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: word with nothing expected: event %0d pressed %0b",
                         $time, ev_if.key_event, ev_if.is_pressed);
                n_errors++;
            end else begin
                got_word = pending_events.pop_front();
                if (ev_if.key_event !== got_word.ev || ev_if.is_pressed !== got_word.pressed) begin
                    $display("%0t: expected event %0d pressed %0b, actual event %0d pressed %0b",
                             $time, got_word.ev, got_word.pressed,
                             ev_if.key_event, ev_if.is_pressed);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int bursts;
        int phase_start;
        smp_if.valid     <= 1'b0;
        smp_if.key_level <= 1'b0;
        smp_if.now_ms    <= '0;
        reg_if.valid     <= 1'b0;
        reg_if.index     <= REG_DEBOUNCE;
        reg_if.data      <= '0;
        key_phase = PH_IDLE;
        mark_ms   = '0;
        held      = 1'b0;
        long_seen = 1'b0;
        click_cnt = '0;
        deb_ms    = DEBOUNCE_RST;
        long_ms   = LONG_RST;
        gap_ms    = GAP_RST;
        clock_ms  = 32'h0002_0000;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < $size(PLAN); r++)
            drive_sample(PLAN[r].lvl, PLAN[r].stamp, PLAN[r].fixed,
                         '{PLAN[r].ev, PLAN[r].pressed});

        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: program_thresholds(16'd0, 16'd0, 16'd0);
                    2: program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    3: program_thresholds(16'd40, 16'd5, 16'd3);
                    6: program_thresholds(16'd1, 16'hFFFF, 16'd0);
                    default: program_thresholds(t_cfg_val'($urandom_range(0, 60)),
                                                t_cfg_val'($urandom_range(0, 1500)),
                                                t_cfg_val'($urandom_range(0, 500)));
                endcase
            end
            phase_start = n_samples;
            bursts = 0;
            while (n_samples - phase_start < PHASE_ITEMS) begin
                // hold off the sender until every word is back
                if (bursts == 6) settle();
                play_burst();
                bursts++;
            end
        end

        settle();
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_intf.sv
hw/rtl/button_click_classifier_core.sv
verif/button_click_classifier_core_tb.sv
